FILE: sv/agbp_pkg.sv
// agbp_pkg: widths, register codes and fixed-point helpers for the audio
// gate / band-pass / pre-emphasis chain. No dependencies.
package agbp_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int STATE_BITS  = 24;
  localparam int COEF_BITS   = 16;
  localparam int FRAC_BITS   = 16;                        // coefficient LSB = 2^-16
  localparam int PEAK_BITS   = SAMPLE_BITS - 1;
  localparam int OPND_BITS   = STATE_BITS + 1;            // filter differences
  localparam int PROD_BITS   = COEF_BITS + OPND_BITS + 2; // product plus accumulate
  localparam int RND_BITS    = PROD_BITS - FRAC_BITS;
  localparam int CFG_DATA_BITS = COEF_BITS;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [COEF_BITS-1:0] LOWPASS_RESET = '1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [STATE_BITS-1:0]  state_t;
  typedef logic        [COEF_BITS-1:0]   coef_t;
  typedef logic signed [OPND_BITS-1:0]   opnd_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [RND_BITS-1:0]    rnd_t;
  typedef logic        [PEAK_BITS-1:0]   peak_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CHAIN_ENABLE   = 3'd0,
    CFG_GATE_THRESHOLD = 3'd1,
    CFG_HIGHPASS_COEF  = 3'd2,
    CFG_LOWPASS_COEF   = 3'd3,
    CFG_EMPHASIS_COEF  = 3'd4
  } cfg_idx_t;

  // Round to nearest LSB, ties toward +inf, then drop the Q0.16 fraction.
  function automatic rnd_t round_q16(input prod_t p);
    prod_t t;
    t = p + $signed(PROD_BITS'(1) <<< (FRAC_BITS - 1));
    return t[PROD_BITS-1:FRAC_BITS];
  endfunction

  // Clamp to the signed filter state range.
  function automatic state_t sat_state(input rnd_t v);
    rnd_t hi;
    rnd_t lo;
    hi = RND_BITS'({1'b0, {(STATE_BITS-1){1'b1}}});
    lo = ~hi;
    if (v > hi)      return hi[STATE_BITS-1:0];
    else if (v < lo) return lo[STATE_BITS-1:0];
    else             return v[STATE_BITS-1:0];
  endfunction

endpackage

FILE: sv/agbp_if.sv
// Valid/ready word channels for samples in and conditioned samples out.
// Depends on agbp_pkg.
interface agbp_in_if import agbp_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    block_last;

  modport source (output valid, output sample_in, output block_last, input ready);
  modport sink   (input valid, input sample_in, input block_last, output ready);
endinterface

interface agbp_out_if import agbp_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  peak_t   block_peak;
  logic    clipped;

  modport source (output valid, output sample_out, output block_peak, output clipped,
                  input ready);
  modport sink   (input valid, input sample_out, input block_peak, input clipped,
                  output ready);
endinterface

FILE: sv/audio_gate_bandpass_preemphasis_top.sv
// Audio gate -> one-pole high-pass -> one-pole low-pass -> pre-emphasis.
// With the chain enabled a word passes through ST_HP, ST_EM and ST_LP (three
// multiplies) and then ST_FIN; bypassed, it goes straight to ST_FIN.
// A new input word is accepted only in ST_IDLE, once the previous word has
// finished, so words do not overlap; the one shared multiplier does three
// products per word. A stalled output word holds the finish step and the input.
// Reset (rst_n low, synchronous): filter state and peak cleared, registers
// at defaults (lowpass_coef all ones), no output word pending.
module audio_gate_bandpass_preemphasis_top import agbp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  agbp_in_if.sink                  in_ch,
  agbp_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, // waiting for a word
    ST_HP,   // multiply high-pass
    ST_EM,   // finish high-pass, multiply pre-emphasis tap
    ST_LP,   // hold emphasis term, multiply low-pass
    ST_FIN   // finish low-pass, emphasis, saturate, peak, load output
  } seq_state_t;

  seq_state_t state_r;

  // configuration registers
  logic                  enable_r;
  logic [PEAK_BITS-1:0]  threshold_r;
  coef_t                 hp_coef_r;
  coef_t                 lp_coef_r;
  coef_t                 em_coef_r;

  // filter state
  state_t  hp_out_r;
  sample_t hp_in_r;
  state_t  lp_out_r;
  state_t  emph_in_r;
  peak_t   peak_r;

  // per-word working registers
  sample_t x_r;      // gated (or raw, when bypassed) input
  logic    last_r;
  logic    bypass_r;
  state_t  em_r;     // rounded ec * previous low-pass output

  // output register
  logic    out_valid_r;
  sample_t out_sample_r;
  peak_t   out_peak_r;
  logic    out_clip_r;

  // shared multiplier
  coef_t   mul_coef;
  opnd_t   mul_opnd;
  prod_t   prod_r;

  agbp_mul u_mul (
    .clk    (clk),
    .coef   (mul_coef),
    .opnd   (mul_opnd),
    .prod_r (prod_r)
  );

  // The low-pass operands stay applied through the finish step, so the
  // product is still valid while the output word is stalled.
  always_comb begin
    case (state_r)
      ST_HP: begin
        mul_coef = hp_coef_r;
        mul_opnd = OPND_BITS'(hp_out_r) + OPND_BITS'(x_r) - OPND_BITS'(hp_in_r);
      end
      ST_EM: begin
        mul_coef = em_coef_r;
        mul_opnd = OPND_BITS'(emph_in_r);
      end
      ST_LP, ST_FIN: begin
        mul_coef = lp_coef_r;
        mul_opnd = OPND_BITS'(hp_out_r) - OPND_BITS'(lp_out_r);
      end
      default: begin
        mul_coef = '0;
        mul_opnd = '0;
      end
    endcase
  end

  // Gate on input: with the chain enabled, magnitude strictly below threshold forces zero.
  logic [SAMPLE_BITS:0] in_mag;
  sample_t              x_nxt;

  always_comb begin
    in_mag = in_ch.sample_in[SAMPLE_BITS-1] ?
             (SAMPLE_BITS+1)'(-$signed({in_ch.sample_in[SAMPLE_BITS-1], in_ch.sample_in})) :
             (SAMPLE_BITS+1)'(in_ch.sample_in);
    if (enable_r && (in_mag < (SAMPLE_BITS+1)'(threshold_r)))
      x_nxt = '0;
    else
      x_nxt = in_ch.sample_in;
  end

  // High-pass result from its product.
  state_t hp_nxt;
  assign hp_nxt = sat_state(round_q16(prod_r));

  // Rounded pre-emphasis tap; fits the state width since ec < 1.
  rnd_t em_rnd;
  assign em_rnd = round_q16(prod_r);

  // Low-pass: lc*h + (1-lc)*l_prev == l_prev*2^16 + lc*(h - l_prev).
  prod_t  lp_acc;
  state_t lp_nxt;
  assign lp_acc = prod_r + (PROD_BITS'(lp_out_r) <<< FRAC_BITS);
  assign lp_nxt = sat_state(round_q16(lp_acc));

  // Pre-emphasis and symmetric output saturation.
  localparam int EMPH_BITS = STATE_BITS + 1;
  localparam logic signed [EMPH_BITS-1:0] SMAX =
    EMPH_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});

  logic signed [EMPH_BITS-1:0] emph_diff;
  sample_t                     result_nxt;
  logic                        clip_nxt;

  always_comb begin
    emph_diff = EMPH_BITS'(lp_nxt) - EMPH_BITS'(em_r);
    clip_nxt  = 1'b0;
    if (bypass_r) begin
      result_nxt = x_r;
    end else if (emph_diff > SMAX) begin
      result_nxt = SAMPLE_BITS'(SMAX);
      clip_nxt   = 1'b1;
    end else if (emph_diff < -SMAX) begin
      result_nxt = SAMPLE_BITS'(-SMAX);
      clip_nxt   = 1'b1;
    end else begin
      result_nxt = emph_diff[SAMPLE_BITS-1:0];
    end
  end

  // Running peak; the most negative sample saturates to full scale.
  logic [SAMPLE_BITS:0] res_mag;
  peak_t                mag_sat;
  peak_t                peak_nxt;

  always_comb begin
    res_mag = result_nxt[SAMPLE_BITS-1] ?
              (SAMPLE_BITS+1)'(-$signed({result_nxt[SAMPLE_BITS-1], result_nxt})) :
              (SAMPLE_BITS+1)'(result_nxt);
    mag_sat  = (res_mag[SAMPLE_BITS:PEAK_BITS] != '0) ? '1 : res_mag[PEAK_BITS-1:0];
    peak_nxt = (mag_sat > peak_r) ? mag_sat : peak_r;
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.block_peak = out_peak_r;
  assign out_ch.clipped    = out_clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b0;
      threshold_r <= '0;
      hp_coef_r   <= '0;
      lp_coef_r   <= LOWPASS_RESET;
      em_coef_r   <= '0;
      hp_out_r    <= '0;
      hp_in_r     <= '0;
      lp_out_r    <= '0;
      emph_in_r   <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHAIN_ENABLE:   enable_r    <= cfg_data[0];
          CFG_GATE_THRESHOLD: threshold_r <= cfg_data[PEAK_BITS-1:0];
          CFG_HIGHPASS_COEF:  hp_coef_r   <= cfg_data[COEF_BITS-1:0];
          CFG_LOWPASS_COEF:   lp_coef_r   <= cfg_data[COEF_BITS-1:0];
          CFG_EMPHASIS_COEF:  em_coef_r   <= cfg_data[COEF_BITS-1:0];
          default: ;
        endcase
      end

      // new word loads as the old one leaves, else valid drops on accept
      if ((state_r == ST_FIN) && out_free)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            x_r      <= x_nxt;
            last_r   <= in_ch.block_last;
            bypass_r <= !enable_r;
            state_r  <= enable_r ? ST_HP : ST_FIN;
          end
        end
        ST_HP: state_r <= ST_EM;
        ST_EM: begin
          hp_out_r <= hp_nxt;
          hp_in_r  <= x_r;
          state_r  <= ST_LP;
        end
        ST_LP: begin
          em_r    <= em_rnd[STATE_BITS-1:0];
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            if (!bypass_r) begin
              lp_out_r  <= lp_nxt;
              emph_in_r <= lp_nxt;
            end
            out_sample_r <= result_nxt;
            out_peak_r   <= peak_nxt;
            out_clip_r   <= clip_nxt;
            peak_r       <= last_r ? '0 : peak_nxt;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/agbp_mul.sv
// agbp_mul: shared coefficient multiplier, unsigned Q0.16 times signed
// operand, product registered. Depends on agbp_pkg.
module agbp_mul import agbp_pkg::*; (
  input  logic  clk,
  input  coef_t coef,
  input  opnd_t opnd,
  output prod_t prod_r
);

  logic signed [COEF_BITS+OPND_BITS:0] prod_nxt;

  assign prod_nxt = $signed({1'b0, coef}) * opnd;

  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(prod_nxt);
  end

endmodule
